// ===== rtl/bivariate_polynomial_eval_defines.svh =====
// Assertion macros shared by the checker of the bivariate polynomial evaluator.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef BIVARIATE_POLYNOMIAL_EVAL_DEFINES_SVH
`define BIVARIATE_POLYNOMIAL_EVAL_DEFINES_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define BPE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the antecedent implies the consequent in the next cycle.
`define BPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bpe_pkg.sv =====
// Package of the bivariate polynomial evaluator: sizes, codes and shared types.
// No dependencies; RTL files but bpe_ram and the macro header use scoped names; the bench imports it.
`default_nettype none

package bpe_pkg;

    localparam int MAX_DEGREE = 7;
    localparam int NUM_TERMS  = 36;

    localparam int DEG_W     = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;
    localparam int POW_N     = MAX_DEGREE + 1;
    localparam int MAX_TERMS = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
    localparam int TERM_W    = $clog2(MAX_TERMS + 1);
    localparam int ADDR_W    = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;

    localparam int IDX_W     = 6;
    localparam int COEF_W    = 32;
    localparam int COORD_W   = 32;
    localparam int CFG_W     = 32;
    localparam int DEGREE_W  = 4;
    localparam int Q_W       = 32;
    localparam int RES_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE   = 3'd4;

    localparam logic signed [Q_W-1:0] ONE_Q24 = 32'sh0100_0000;

    typedef enum logic [1:0] {
        MODE_MAP = 2'd0,
        MODE_Q24 = 2'd1,
        MODE_ACC = 2'd2
    } mul_mode_t;

    typedef struct packed {
        logic      issue;
        logic      clear;
        mul_mode_t mode;
    } mul_cmd_t;

    typedef struct packed {
        logic signed [Q_W-1:0]   value;
        logic signed [RES_W-1:0] sum;
        logic                    flag;
    } mul_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bpe_if.sv =====
// Handshake interfaces of the bivariate polynomial evaluator: input, result and configuration.
// Depends on bpe_pkg for the field widths.
`default_nettype none

interface bpe_in_if;
    logic                               valid;
    logic                               ready;
    logic                               op;
    logic [bpe_pkg::IDX_W-1:0]          coef_index;
    logic signed [bpe_pkg::COEF_W-1:0]  coef_value;
    logic signed [bpe_pkg::COORD_W-1:0] x_coord;
    logic signed [bpe_pkg::COORD_W-1:0] y_coord;

    modport source (output valid, op, coef_index, coef_value, x_coord, y_coord, input ready);
    modport sink   (input valid, op, coef_index, coef_value, x_coord, y_coord, output ready);
endinterface

interface bpe_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [bpe_pkg::RES_W-1:0] poly_value;
    logic                             saturated;

    modport source (output valid, poly_value, saturated, input ready);
    modport sink   (input valid, poly_value, saturated, output ready);
endinterface

interface bpe_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bpe_pkg::CFG_IDX_W-1:0]  index;
    logic [bpe_pkg::CFG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bivariate_polynomial_eval.sv =====
// Bivariate polynomial evaluator. A load word (op 0) writes one coefficient, unless its index
// lies beyond the store, and the block stays ready. An evaluate word (op 1) runs on one shared
// 32x32 multiplier, each multiply a product step followed by a write-back step; a negative
// degree skips the multiplies. The input is not ready meanwhile, but a finished result
// waits in its own output register while the next word is taken.
// The coefficient store is a RAM with one valid flag per entry, cleared by reset.
// Depends on bpe_pkg, bpe_if, bpe_ram and bpe_mul_unit.
`default_nettype none

module bivariate_polynomial_eval (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bpe_in_if.sink     item,
    bpe_out_if.source  result,
    bpe_cfg_if.sink    cfg
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_MAPX   = 14'b00000000000010,
        S_MAPX_W = 14'b00000000000100,
        S_MAPY   = 14'b00000000001000,
        S_MAPY_W = 14'b00000000010000,
        S_POWX   = 14'b00000000100000,
        S_POWX_W = 14'b00000001000000,
        S_POWY   = 14'b00000010000000,
        S_POWY_W = 14'b00000100000000,
        S_MONO   = 14'b00001000000000,
        S_MONO_W = 14'b00010000000000,
        S_TERM   = 14'b00100000000000,
        S_TERM_W = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic signed [bpe_pkg::Q_W-1:0]      x_gain_reg;
    logic signed [bpe_pkg::Q_W-1:0]      x_offset_reg;
    logic signed [bpe_pkg::Q_W-1:0]      y_gain_reg;
    logic signed [bpe_pkg::Q_W-1:0]      y_offset_reg;
    logic signed [bpe_pkg::DEGREE_W-1:0] degree_reg;

    logic [bpe_pkg::NUM_TERMS-1:0]       coef_valid_reg;
    logic [bpe_pkg::DEG_W-1:0]           deg_reg;
    logic [bpe_pkg::DEG_W-1:0]           deg_clamped;
    logic [bpe_pkg::DEG_W-1:0]           pw_reg;
    logic [bpe_pkg::DEG_W-1:0]           ix_reg;
    logic [bpe_pkg::DEG_W-1:0]           iy_reg;
    logic [bpe_pkg::TERM_W-1:0]          k_reg;

    logic signed [bpe_pkg::COORD_W-1:0]  xc_reg;
    logic signed [bpe_pkg::COORD_W-1:0]  yc_reg;
    logic signed [bpe_pkg::Q_W-1:0]      x_reg;
    logic signed [bpe_pkg::Q_W-1:0]      y_reg;
    logic signed [bpe_pkg::Q_W-1:0]      last_reg;
    logic signed [bpe_pkg::Q_W-1:0]      mono_reg;
    logic signed [bpe_pkg::Q_W-1:0]      xp_reg [bpe_pkg::POW_N];
    logic signed [bpe_pkg::Q_W-1:0]      yp_reg [bpe_pkg::POW_N];

    logic                                res_valid_reg;
    logic signed [bpe_pkg::RES_W-1:0]    res_value_reg;
    logic                                res_sat_reg;

    logic                                in_acc;
    logic                                eval_acc;
    logic                                load_we;
    logic [bpe_pkg::ADDR_W-1:0]          load_addr;
    logic [bpe_pkg::ADDR_W-1:0]          k_addr;
    logic                                k_in_store;
    logic [bpe_pkg::DEG_W-1:0]           row_len;
    logic                                last_in_row;
    logic                                last_term;
    logic                                advance;
    logic                                res_load;
    logic [bpe_pkg::COEF_W-1:0]          coef_rdata;
    logic signed [bpe_pkg::COEF_W-1:0]   coef_op;

    bpe_pkg::mul_cmd_t                   cmd;
    bpe_pkg::mul_rsp_t                   rsp;
    logic signed [bpe_pkg::Q_W-1:0]      op_a;
    logic signed [bpe_pkg::Q_W-1:0]      op_b;
    logic signed [bpe_pkg::Q_W-1:0]      op_offset;

    assign cfg.ready  = 1'b1;
    assign item.ready = (state_reg == S_IDLE);
    assign in_acc     = item.valid && item.ready;
    assign eval_acc   = in_acc && (item.op == bpe_pkg::OP_EVAL);
    assign load_we    = in_acc && (item.op == bpe_pkg::OP_LOAD)
                        && (item.coef_index < bpe_pkg::NUM_TERMS);
    assign load_addr  = bpe_pkg::ADDR_W'(item.coef_index);

    assign deg_clamped = ($signed(degree_reg) > bpe_pkg::MAX_DEGREE)
                         ? bpe_pkg::DEG_W'(bpe_pkg::MAX_DEGREE)
                         : bpe_pkg::DEG_W'(degree_reg);

    assign k_addr      = bpe_pkg::ADDR_W'(k_reg);
    assign k_in_store  = k_reg < bpe_pkg::NUM_TERMS;
    assign row_len     = deg_reg - ix_reg;
    assign last_in_row = iy_reg == row_len;
    assign last_term   = last_in_row && (ix_reg == deg_reg);
    assign advance     = ((state_reg == S_MONO_W) && !k_in_store) || (state_reg == S_TERM_W);
    assign res_load    = (state_reg == S_DONE) && (!res_valid_reg || result.ready);
    assign coef_op     = coef_valid_reg[k_addr] ? $signed(coef_rdata) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_gain_reg   <= bpe_pkg::ONE_Q24;
            x_offset_reg <= '0;
            y_gain_reg   <= bpe_pkg::ONE_Q24;
            y_offset_reg <= '0;
            degree_reg   <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                bpe_pkg::CFG_X_GAIN:   x_gain_reg   <= $signed(cfg.data);
                bpe_pkg::CFG_X_OFFSET: x_offset_reg <= $signed(cfg.data);
                bpe_pkg::CFG_Y_GAIN:   y_gain_reg   <= $signed(cfg.data);
                bpe_pkg::CFG_Y_OFFSET: y_offset_reg <= $signed(cfg.data);
                bpe_pkg::CFG_DEGREE:   degree_reg   <= $signed(cfg.data[bpe_pkg::DEGREE_W-1:0]);
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (eval_acc)
                begin
                    state_next = degree_reg[bpe_pkg::DEGREE_W-1] ? S_DONE : S_MAPX;
                end
            end
            S_MAPX:   state_next = S_MAPX_W;
            S_MAPX_W: state_next = S_MAPY;
            S_MAPY:   state_next = S_MAPY_W;
            S_MAPY_W: state_next = (deg_reg == '0) ? S_MONO : S_POWX;
            S_POWX:   state_next = S_POWX_W;
            S_POWX_W: state_next = (pw_reg == deg_reg) ? S_POWY : S_POWX;
            S_POWY:   state_next = S_POWY_W;
            S_POWY_W: state_next = (pw_reg == deg_reg) ? S_MONO : S_POWY;
            S_MONO:   state_next = S_MONO_W;
            S_MONO_W:
            begin
                if (k_in_store)
                begin
                    state_next = S_TERM;
                end
                else
                begin
                    state_next = last_term ? S_DONE : S_MONO;
                end
            end
            S_TERM:   state_next = S_TERM_W;
            S_TERM_W: state_next = last_term ? S_DONE : S_MONO;
            S_DONE:   state_next = res_load ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            coef_valid_reg <= '0;
            deg_reg        <= '0;
            pw_reg         <= '0;
            ix_reg         <= '0;
            iy_reg         <= '0;
            k_reg          <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_we)
            begin
                coef_valid_reg[load_addr] <= 1'b1;
            end
            if (eval_acc)
            begin
                deg_reg <= deg_clamped;
            end
            if (state_reg == S_MAPY_W)
            begin
                pw_reg <= bpe_pkg::DEG_W'(1);
                ix_reg <= '0;
                iy_reg <= '0;
                k_reg  <= '0;
            end
            else if (state_reg == S_POWX_W)
            begin
                pw_reg <= (pw_reg == deg_reg) ? bpe_pkg::DEG_W'(1) : pw_reg + 1'b1;
            end
            else if (state_reg == S_POWY_W)
            begin
                pw_reg <= pw_reg + 1'b1;
            end
            if (advance)
            begin
                if (last_in_row)
                begin
                    ix_reg <= ix_reg + 1'b1;
                    iy_reg <= '0;
                end
                else
                begin
                    iy_reg <= iy_reg + 1'b1;
                end
                k_reg <= k_reg + 1'b1;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.valid && result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_acc)
        begin
            xc_reg <= item.x_coord;
            yc_reg <= item.y_coord;
        end
        case (state_reg)
            S_MAPX_W: x_reg <= rsp.value;
            S_MAPY_W:
            begin
                y_reg     <= rsp.value;
                last_reg  <= bpe_pkg::ONE_Q24;
                xp_reg[0] <= bpe_pkg::ONE_Q24;
                yp_reg[0] <= bpe_pkg::ONE_Q24;
            end
            S_POWX_W:
            begin
                xp_reg[pw_reg] <= rsp.value;
                last_reg       <= (pw_reg == deg_reg) ? bpe_pkg::ONE_Q24 : rsp.value;
            end
            S_POWY_W:
            begin
                yp_reg[pw_reg] <= rsp.value;
                last_reg       <= rsp.value;
            end
            S_MONO_W: mono_reg <= rsp.value;
            default:  ;
        endcase
        if (res_load)
        begin
            res_value_reg <= rsp.sum;
            res_sat_reg   <= rsp.flag;
        end
    end

    always_comb
    begin
        cmd.issue = 1'b0;
        cmd.clear = eval_acc;
        cmd.mode  = bpe_pkg::MODE_Q24;
        op_a      = '0;
        op_b      = '0;
        op_offset = '0;
        case (state_reg)
            S_MAPX:
            begin
                cmd.issue = 1'b1;
                cmd.mode  = bpe_pkg::MODE_MAP;
                op_a      = x_gain_reg;
                op_b      = xc_reg;
                op_offset = x_offset_reg;
            end
            S_MAPY:
            begin
                cmd.issue = 1'b1;
                cmd.mode  = bpe_pkg::MODE_MAP;
                op_a      = y_gain_reg;
                op_b      = yc_reg;
                op_offset = y_offset_reg;
            end
            S_POWX:
            begin
                cmd.issue = 1'b1;
                op_a      = last_reg;
                op_b      = x_reg;
            end
            S_POWY:
            begin
                cmd.issue = 1'b1;
                op_a      = last_reg;
                op_b      = y_reg;
            end
            S_MONO:
            begin
                cmd.issue = 1'b1;
                op_a      = xp_reg[ix_reg];
                op_b      = yp_reg[iy_reg];
            end
            S_TERM:
            begin
                cmd.issue = 1'b1;
                cmd.mode  = bpe_pkg::MODE_ACC;
                op_a      = mono_reg;
                op_b      = coef_op;
            end
            default: ;
        endcase
    end

    bpe_ram #(
        .WIDTH (bpe_pkg::COEF_W),
        .DEPTH (bpe_pkg::NUM_TERMS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (item.coef_value),
        .re    (state_reg == S_MONO_W),
        .raddr (k_addr),
        .rdata (coef_rdata)
    );

    bpe_mul_unit u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .a      (op_a),
        .b      (op_b),
        .offset (op_offset),
        .rsp    (rsp)
    );

    assign result.valid      = res_valid_reg;
    assign result.poly_value = res_value_reg;
    assign result.saturated  = res_sat_reg;

endmodule

`default_nettype wire

// ===== rtl/bpe_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; width and depth are set by its parameters.
`default_nettype none

module bpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 36
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bpe_mul_unit.sv =====
// Shared multiplier of the evaluator with its write-back stage: mapping, Q8.24 product, MAC.
// Depends on bpe_pkg for the command and response types.
`default_nettype none

module bpe_mul_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bpe_pkg::mul_cmd_t                 cmd,
    input  wire logic signed [bpe_pkg::Q_W-1:0]    a,
    input  wire logic signed [bpe_pkg::Q_W-1:0]    b,
    input  wire logic signed [bpe_pkg::Q_W-1:0]    offset,
    output bpe_pkg::mul_rsp_t                      rsp
);

    logic signed [bpe_pkg::RES_W-1:0] prod_reg;
    logic signed [bpe_pkg::RES_W-1:0] prod_next;
    logic signed [bpe_pkg::Q_W-1:0]   offset_reg;
    bpe_pkg::mul_mode_t               mode_reg;
    logic                             wb_reg;
    logic signed [bpe_pkg::RES_W-1:0] sum_reg;
    logic                             flag_reg;

    logic signed [bpe_pkg::RES_W-1:0] map_sum;
    logic [bpe_pkg::RES_W-1:0]        shifted;
    logic                             q_ovf;
    logic signed [bpe_pkg::Q_W-1:0]   q_value;
    logic [bpe_pkg::RES_W:0]          acc_wide;
    logic                             acc_ovf;
    logic signed [bpe_pkg::RES_W-1:0] acc_value;
    logic                             sat_now;

    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            prod_reg   <= prod_next;
            offset_reg <= offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg   <= 1'b0;
            mode_reg <= bpe_pkg::MODE_MAP;
            sum_reg  <= '0;
            flag_reg <= 1'b0;
        end
        else
        begin
            wb_reg <= cmd.issue;
            if (cmd.issue)
            begin
                mode_reg <= cmd.mode;
            end
            if (cmd.clear)
            begin
                sum_reg  <= '0;
                flag_reg <= 1'b0;
            end
            else if (wb_reg)
            begin
                if (mode_reg == bpe_pkg::MODE_ACC)
                begin
                    sum_reg <= acc_value;
                end
                flag_reg <= flag_reg | sat_now;
            end
        end
    end

    // The offset is aligned to the product's binary point before the sum.
    assign map_sum = prod_reg + {{16{offset_reg[bpe_pkg::Q_W-1]}}, offset_reg, 16'b0};

    always_comb
    begin
        case (mode_reg)
            bpe_pkg::MODE_MAP: shifted = {{16{map_sum[63]}}, map_sum[63:16]};
            bpe_pkg::MODE_Q24: shifted = {{24{prod_reg[63]}}, prod_reg[63:24]};
            default:           shifted = {{24{prod_reg[63]}}, prod_reg[63:24]};
        endcase
    end

    assign q_ovf   = !((&shifted[63:31]) || !(|shifted[63:31]));
    assign q_value = q_ovf ? (shifted[63] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                           : $signed(shifted[31:0]);

    assign acc_wide  = {sum_reg[63], sum_reg} + {prod_reg[63], prod_reg};
    assign acc_ovf   = acc_wide[64] != acc_wide[63];
    assign acc_value = acc_ovf ? (acc_wide[64] ? 64'sh8000_0000_0000_0000
                                               : 64'sh7fff_ffff_ffff_ffff)
                               : $signed(acc_wide[63:0]);

    assign sat_now = (mode_reg == bpe_pkg::MODE_ACC) ? acc_ovf : q_ovf;

    assign rsp.value = q_value;
    assign rsp.sum   = sum_reg;
    assign rsp.flag  = flag_reg;

endmodule

`default_nettype wire

// ===== rtl/bpe_checker.sv =====
// Port-level checker of the bivariate polynomial evaluator and its bind to the top level.
// Depends on bpe_pkg and the assertion macros in bivariate_polynomial_eval_defines.svh.
`default_nettype none

`include "bivariate_polynomial_eval_defines.svh"

module bpe_port_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             in_op,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic signed [bpe_pkg::RES_W-1:0] poly_value,
    input wire logic                             saturated
);

    logic                    eval_fire;
    logic                    load_fire;
    logic                    out_stall;
    logic [bpe_pkg::RES_W:0] out_word;

    assign eval_fire = in_valid && in_ready && (in_op == bpe_pkg::OP_EVAL);
    assign load_fire = in_valid && in_ready && (in_op == bpe_pkg::OP_LOAD);
    assign out_stall = out_valid && !out_ready;
    assign out_word  = {poly_value, saturated};

    `BPE_ASSERT_NEXT(a_eval_busy, eval_fire, !in_ready, "evaluate word left the input ready")
    `BPE_ASSERT_NEXT(a_load_single, load_fire, in_ready, "load word left the input busy")
    `BPE_ASSERT_NOW(a_result_idle, $rose(out_valid), in_ready, "result word rose while busy")
    `BPE_ASSERT_NEXT(a_result_hold, out_stall, out_valid && $stable(out_word), "held word changed")

endmodule

bind bivariate_polynomial_eval bpe_port_checker u_bpe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .in_op      (item.op),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .poly_value (result.poly_value),
    .saturated  (result.saturated)
);

`default_nettype wire

// ===== sim/bpe_checker.sv =====
// Scoreboard for the bivariate polynomial evaluator: it watches the item, result and
// configuration channels, predicts every evaluation and compares it with the result word.
// Depends on bpe_pkg and the channel interfaces in bpe_if.
module bpe_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    bpe_in_if         item,
    bpe_out_if        result,
    bpe_cfg_if        cfg,
    output int        fail_count,
    output int        waiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import bpe_pkg::*;

    localparam longint Q32_MAX = 2147483647;
    localparam longint Q32_MIN = -Q32_MAX - 1;
    localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    typedef struct {
        logic signed [RES_W-1:0] value;
        logic                    sat;
    } poly_word_t;

    poly_word_t poly_due[$];

    logic signed [Q_W-1:0]      x_gain_q;
    logic signed [Q_W-1:0]      x_off_q;
    logic signed [Q_W-1:0]      y_gain_q;
    logic signed [Q_W-1:0]      y_off_q;
    logic signed [DEGREE_W-1:0] degree_q;
    logic signed [COEF_W-1:0]   coef_q [NUM_TERMS];
    int                         mismatches = 0;

    assign fail_count = mismatches;

    function automatic longint clamp_q32(input longint v, inout logic sat);
        if (v > Q32_MAX)
        begin
            sat = 1'b1;
            return Q32_MAX;
        end
        if (v < Q32_MIN)
        begin
            sat = 1'b1;
            return Q32_MIN;
        end
        return v;
    endfunction

    function automatic longint mul_q24(input longint a, input longint b, inout logic sat);
        return clamp_q32((a * b) >>> 24, sat);
    endfunction

    function automatic longint map_axis(input longint gain, input longint offset,
                                        input longint coord, inout logic sat);
        return clamp_q32((gain * coord + offset * 65536) >>> 16, sat);
    endfunction

    function automatic longint add_sat(input longint a, input longint b, inout logic sat);
        if (b > 0 && a > SUM_MAX - b)
        begin
            sat = 1'b1;
            return SUM_MAX;
        end
        if (b < 0 && a < SUM_MIN - b)
        begin
            sat = 1'b1;
            return SUM_MIN;
        end
        return a + b;
    endfunction

    // Terms are visited with the x power outer and the y power inner, as the store is laid out.
    function automatic poly_word_t predict_poly(input longint xc, input longint yc);
        poly_word_t w;
        longint     x;
        longint     y;
        longint     xp;
        longint     yp;
        longint     mono;
        longint     sum;
        logic       sat;
        int         deg;
        int         k;
        sat = 1'b0;
        sum = 0;
        k   = 0;
        deg = int'(degree_q);
        if (deg > MAX_DEGREE)
            deg = MAX_DEGREE;
        if (deg >= 0)
        begin
            x  = map_axis(x_gain_q, x_off_q, xc, sat);
            y  = map_axis(y_gain_q, y_off_q, yc, sat);
            xp = ONE_Q24;
            for (int i = 0; i <= deg; i++)
            begin
                yp = ONE_Q24;
                if (i > 0)
                    xp = mul_q24(xp, x, sat);
                for (int j = 0; j <= deg - i; j++)
                begin
                    if (j > 0)
                        yp = mul_q24(yp, y, sat);
                    mono = mul_q24(xp, yp, sat);
                    if (k < NUM_TERMS)
                        sum = add_sat(sum, mono * longint'(coef_q[k]), sat);
                    k++;
                end
            end
        end
        w.value = sum;
        w.sat   = sat;
        return w;
    endfunction

    task automatic report(input string what, input logic [RES_W-1:0] got,
                          input logic [RES_W-1:0] want);
        if (mismatches < 100)
            $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        poly_word_t want;
        if (!rst_n)
        begin
            x_gain_q <= ONE_Q24;
            x_off_q  <= '0;
            y_gain_q <= ONE_Q24;
            y_off_q  <= '0;
            degree_q <= '0;
            for (int k = 0; k < NUM_TERMS; k++)
                coef_q[k] <= '0;
            poly_due.delete();
            waiting <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_X_GAIN:   x_gain_q <= cfg.data;
                    CFG_X_OFFSET: x_off_q  <= cfg.data;
                    CFG_Y_GAIN:   y_gain_q <= cfg.data;
                    CFG_Y_OFFSET: y_off_q  <= cfg.data;
                    CFG_DEGREE:   degree_q <= cfg.data[DEGREE_W-1:0];
                    default:      ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (poly_due.size() == 0)
                    report("result word with nothing outstanding", result.poly_value, '0);
                else
                begin
                    want = poly_due.pop_front();
                    if (result.poly_value !== want.value)
                        report("poly_value", result.poly_value, want.value);
                    if (result.saturated !== want.sat)
                        report("saturated", RES_W'(result.saturated), RES_W'(want.sat));
                end
            end
            if (item.valid && item.ready)
            begin
                if (item.op == OP_LOAD)
                begin
                    if (item.coef_index < NUM_TERMS)
                        coef_q[item.coef_index] <= item.coef_value;
                end
                else
                    poly_due.push_back(predict_poly(item.x_coord, item.y_coord));
            end
            waiting <= poly_due.size();
        end
    end

endmodule

// ===== sim/tb_bivariate_polynomial_eval.sv =====
// Testbench top for the bivariate polynomial evaluator: clock, reset, configuration and
// item stimulus under varying back-pressure, and the final verdict.
// Depends on bpe_pkg, bpe_if, the evaluator RTL and bpe_checker.
module tb_bivariate_polynomial_eval;
    timeunit 1ns;
    timeprecision 1ps;
    import bpe_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_WORDS  = 850;
    localparam int PHASES        = 10;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_IDX_W'(CFG_DEGREE + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPARE  = '1;

    logic clk        = 1'b0;
    logic rst_n      = 1'b0;
    int   send_idle  = 0;
    int   recv_stall = 0;
    int   cycle_count = 0;
    int   fail_count;
    int   waiting;

    bpe_in_if  item_ch ();
    bpe_out_if res_ch ();
    bpe_cfg_if cfg_ch ();

    bivariate_polynomial_eval dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    bpe_checker poly_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (res_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_word(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [COEF_W-1:0] coef,
                             input logic [COORD_W-1:0] xc, input logic [COORD_W-1:0] yc);
        while ($urandom_range(99) < send_idle)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.op         <= op;
        item_ch.coef_index <= idx;
        item_ch.coef_value <= coef;
        item_ch.x_coord    <= xc;
        item_ch.y_coord    <= yc;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    task automatic push_load(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] coef);
        push_word(OP_LOAD, idx, coef, $urandom(), $urandom());
    endtask

    task automatic push_eval(input logic [COORD_W-1:0] xc, input logic [COORD_W-1:0] yc);
        push_word(OP_EVAL, IDX_W'($urandom()), $urandom(), xc, yc);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic end_writes();
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom();
            4:       return $urandom_range(32'h0002_0000) - 32'h0001_0000;
            default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom();
            3:       return ONE_Q24;
            default: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom();
            3:       return '0;
            default: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_degree();
        logic [31:0] w;
        w = $urandom();
        if ($urandom_range(9) < 7)
            w[DEGREE_W-1:0] = DEGREE_W'($urandom_range(MAX_DEGREE));
        return w;
    endfunction

    initial
    begin
        int counted;
        int kind;
        item_ch.valid      = 1'b0;
        item_ch.op         = OP_LOAD;
        item_ch.coef_index = '0;
        item_ch.coef_value = '0;
        item_ch.x_coord    = '0;
        item_ch.y_coord    = '0;
        res_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_X_GAIN;
        cfg_ch.data        = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state first, then store corners and loads that fall outside the store.
        push_eval('0, '0);
        push_load('0, 32'h7FFF_FFFF);
        push_load(IDX_W'(NUM_TERMS - 1), 32'h8000_0000);
        push_load(IDX_W'(NUM_TERMS), 32'h0001_0000);
        push_load('1, $urandom());
        push_load(IDX_W'(20), 32'h0001_0000);
        push_eval(32'h0001_0000, 32'h0001_0000);
        drain();
        write_reg(CFG_DEGREE, MAX_DEGREE);
        end_writes();
        push_eval(32'h0001_0000, 32'h0001_0000);
        push_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_eval(32'h8000_0000, 32'h8000_0000);
        push_eval(32'hFFFF_0000, 32'h0002_0000);

        // Extreme gains and offsets, an empty polynomial and the most negative degree.
        drain();
        write_reg(CFG_X_GAIN, 32'h7FFF_FFFF);
        write_reg(CFG_X_OFFSET, 32'h8000_0000);
        write_reg(CFG_Y_GAIN, 32'h8000_0000);
        write_reg(CFG_Y_OFFSET, 32'h7FFF_FFFF);
        write_reg(CFG_DEGREE, {28'($urandom_range(32'h0FFF_FFFF)), 4'hF});
        write_reg(CFG_IDX_W'($urandom_range(CFG_LAST_SPARE, CFG_FIRST_SPARE)), $urandom());
        end_writes();
        push_eval($urandom(), $urandom());
        drain();
        write_reg(CFG_DEGREE, {28'($urandom_range(32'h0FFF_FFFF)), 4'h8});
        end_writes();
        push_eval($urandom(), $urandom());
        drain();
        write_reg(CFG_DEGREE, MAX_DEGREE);
        end_writes();
        push_eval(32'h0001_0000, 32'hFFFF_0000);

        // Large coefficients against saturated monomials drive the sum into its limit.
        drain();
        write_reg(CFG_X_GAIN, ONE_Q24);
        write_reg(CFG_X_OFFSET, '0);
        write_reg(CFG_Y_GAIN, ONE_Q24);
        write_reg(CFG_Y_OFFSET, '0);
        end_writes();
        push_load(IDX_W'(1), 32'h7FFF_FFFF);
        push_load(IDX_W'(2), 32'h7FFF_FFFF);
        push_load(IDX_W'(3), 32'h7FFF_FFFF);
        push_eval(32'h0064_0000, 32'h0064_0000);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            write_reg(CFG_X_GAIN, pick_gain());
            write_reg(CFG_X_OFFSET, pick_offset());
            write_reg(CFG_Y_GAIN, pick_gain());
            write_reg(CFG_Y_OFFSET, pick_offset());
            write_reg(CFG_DEGREE, pick_degree());
            if ($urandom_range(1))
                write_reg(CFG_IDX_W'($urandom_range(CFG_LAST_SPARE, CFG_FIRST_SPARE)),
                          $urandom());
            end_writes();
            case (p % 4)
                0:
                begin
                    send_idle  <= 0;
                    recv_stall <= 0;
                end
                1:
                begin
                    send_idle  <= 86;
                    recv_stall <= 0;
                end
                2:
                begin
                    send_idle  <= 0;
                    recv_stall <= 86;
                end
                default:
                begin
                    send_idle  <= 19;
                    recv_stall <= 19;
                end
            endcase
            counted = 0;
            while (counted < RANDOM_WORDS / PHASES)
            begin
                kind = $urandom_range(9);
                if (kind < 5)
                    push_eval(pick_q16(), pick_q16());
                else if (kind < 9)
                    push_load(IDX_W'($urandom_range(NUM_TERMS - 1)), pick_q16());
                else
                    push_load(IDX_W'($urandom_range(2**IDX_W - 1, NUM_TERMS)), $urandom());
                counted++;
                if (p == 2 && counted % 20 == 19)
                    drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && waiting == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
